// ===== sv/prle_pkg.sv =====
// ----------------------------------------------------------------------------
// prle_pkg
// Shared types and codes for the page run-length encoder.
// ----------------------------------------------------------------------------
package prle_pkg;

  localparam int unsigned GRP_SLOTS = 4;

  localparam logic [1:0] MODE_COPY = 2'd0;

  localparam logic CFG_IDX_MODE  = 1'b0;
  localparam logic CFG_IDX_LIMIT = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  // one result byte with its side fields
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        status;
    logic [13:0] size;
  } entry_t;

  // all results caused by one input byte
  typedef struct packed {
    entry_t [GRP_SLOTS-1:0] slot;
    logic   [2:0]           cnt;
  } group_t;

endpackage

// ===== sv/prle_out_buf.sv =====
// ----------------------------------------------------------------------------
// prle_out_buf
// Holds the result group of one input byte and sends it one byte per transfer.
// ----------------------------------------------------------------------------
module prle_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  prle_pkg::group_t  grp,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_last,
  output logic              out_status,
  output logic [13:0]       out_total_size
);

  prle_pkg::group_t grp_r;
  logic [1:0]       idx_r;
  logic             busy_r;
  logic             drain_last;
  prle_pkg::entry_t cur;

  assign cur        = grp_r.slot[idx_r];
  assign drain_last = busy_r && !out_stall && (({1'b0, idx_r} + 3'd1) == grp_r.cnt);
  assign ready      = !busy_r || drain_last;

  assign out_valid      = busy_r;
  assign out_byte       = cur.data;
  assign out_last       = cur.last;
  assign out_status     = cur.status;
  assign out_total_size = cur.size;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      idx_r     <= 2'd0;
      grp_r.cnt <= 3'd0;
    end else if (load) begin
      grp_r  <= grp;
      idx_r  <= 2'd0;
      busy_r <= 1'b1;
    end else if (drain_last) begin
      busy_r <= 1'b0;
    end else if (busy_r && !out_stall) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  a_load_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> ready)
    else $error("group loaded while previous group still draining");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (grp_r.cnt != 3'd0 && grp_r.cnt <= 3'd4 && {1'b0, idx_r} < grp_r.cnt))
    else $error("slot index outside group");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && out_stall) |=> (busy_r && $stable(idx_r)))
    else $error("result moved while stalled");

  a_nospace_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cur.status == prle_pkg::STATUS_NO_SPACE) |-> cur.last)
    else $error("no-space result not marked last");

endmodule

// ===== sv/page_run_length_encoder_core.sv =====
// ----------------------------------------------------------------------------
// page_run_length_encoder_core
// Run-length encoder for pages: count/value pairs, copy mode, output limit.
// ----------------------------------------------------------------------------
//  channel | ports                                   | flow
//  --------+-----------------------------------------+---------------------
//  in      | in_valid in_stall in_data_byte in_page_end     | bytes of a page
//  out     | out_valid out_stall out_byte out_last          | result bytes
//          | out_status out_total_size                      |
//  cfg     | cfg_wr_en cfg_index cfg_data                   | mode and limit
//
// An input byte is encoded in the cycle of its transfer and leaves 0 to 4
// result bytes in the output group buffer, which sends one per cycle while
// out_stall is low. in_stall is high while a group is still draining, except
// in the cycle of its last transfer.
// Reset sets mode 1 and limit 8192 and clears run and page state at once.

module page_run_length_encoder_core #(
  parameter int unsigned MAX_RUN   = 255,
  parameter int unsigned LIMIT_MAX = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_page_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_status,
  output logic [13:0] out_total_size,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [13:0] cfg_data
);

  localparam logic [7:0]  MaxRun8   = 8'(MAX_RUN);
  localparam logic [16:0] LimitMax17 = 17'(LIMIT_MAX);

  logic [1:0]  mode_r;
  logic [13:0] limit_r;

  logic [7:0]  run_value_r, run_value_nxt;
  logic [7:0]  run_count_r, run_count_nxt;
  logic [13:0] bytes_out_r, bytes_out_nxt;
  logic        failed_r, failed_nxt;

  logic              buf_ready;
  logic              in_xfer;
  prle_pkg::group_t  grp;

  logic [14:0] lim;
  logic        copy_mode;
  logic        flush_first;
  logic        fail;
  logic [13:0] bo_a;
  logic [7:0]  rc_a;
  logic [14:0] need;

  assign in_stall  = !buf_ready;
  assign in_xfer   = in_valid && !in_stall;
  assign copy_mode = (mode_r == prle_pkg::MODE_COPY);

  // saturate limit
  assign lim = ({3'b000, limit_r} > LimitMax17) ? 15'(LIMIT_MAX) : {1'b0, limit_r};

  always_comb begin
    grp           = '0;
    run_value_nxt = run_value_r;
    run_count_nxt = run_count_r;
    bytes_out_nxt = bytes_out_r;
    failed_nxt    = failed_r;
    fail          = 1'b0;
    bo_a          = bytes_out_r;
    rc_a          = run_count_r;
    need          = '0;
    flush_first   = 1'b0;

    if (failed_r) begin
      if (in_page_end) begin
        run_value_nxt = '0;
        run_count_nxt = '0;
        bytes_out_nxt = '0;
        failed_nxt    = 1'b0;
      end
    end else begin
      flush_first = (run_count_r != 8'd0) &&
                    (copy_mode || in_data_byte != run_value_r || run_count_r >= MaxRun8);
      if (flush_first) begin
        if (({1'b0, bytes_out_r} + 15'd2) > lim) begin
          fail = 1'b1;
        end else begin
          grp.slot[0] = '{data: run_count_r, last: 1'b0, status: prle_pkg::STATUS_OK,
                          size: 14'd0};
          grp.slot[1] = '{data: run_value_r, last: 1'b0, status: prle_pkg::STATUS_OK,
                          size: 14'd0};
          grp.cnt     = 3'd2;
          bo_a        = bytes_out_r + 14'd2;
          rc_a        = 8'd0;
        end
      end

      if (!fail) begin
        if (copy_mode) begin
          need = {1'b0, bo_a} + 15'd1;
          if (need > lim) begin
            fail = 1'b1;
          end else begin
            grp.slot[grp.cnt[1:0]] = '{data: in_data_byte, last: in_page_end,
                                       status: prle_pkg::STATUS_OK,
                                       size: in_page_end ? need[13:0] : 14'd0};
            grp.cnt       = grp.cnt + 3'd1;
            bytes_out_nxt = need[13:0];
            run_count_nxt = 8'd0;
          end
        end else begin
          if (rc_a == 8'd0) begin
            run_value_nxt = in_data_byte;
            run_count_nxt = 8'd1;
          end else begin
            run_value_nxt = run_value_r;
            run_count_nxt = rc_a + 8'd1;
          end
          bytes_out_nxt = bo_a;
          if (in_page_end) begin
            need = {1'b0, bo_a} + 15'd2;
            if (need > lim) begin
              fail = 1'b1;
            end else begin
              grp.slot[grp.cnt[1:0]]        = '{data: run_count_nxt, last: 1'b0,
                                                status: prle_pkg::STATUS_OK, size: 14'd0};
              grp.slot[grp.cnt[1:0] + 2'd1] = '{data: run_value_nxt, last: 1'b1,
                                                status: prle_pkg::STATUS_OK,
                                                size: need[13:0]};
              grp.cnt = grp.cnt + 3'd2;
            end
          end
        end
      end

      // a finished page clears state; fail overrides below
      if (in_page_end && !fail) begin
        run_value_nxt = '0;
        run_count_nxt = '0;
        bytes_out_nxt = '0;
      end

      if (fail) begin
        grp.slot[grp.cnt[1:0]] = '{data: 8'd0, last: 1'b1,
                                   status: prle_pkg::STATUS_NO_SPACE, size: 14'd0};
        grp.cnt       = grp.cnt + 3'd1;
        run_value_nxt = '0;
        run_count_nxt = '0;
        bytes_out_nxt = '0;
        failed_nxt    = !in_page_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 2'd1;
      limit_r     <= 14'd8192;
      run_value_r <= '0;
      run_count_r <= '0;
      bytes_out_r <= '0;
      failed_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          prle_pkg::CFG_IDX_MODE:  mode_r  <= cfg_data[1:0];
          prle_pkg::CFG_IDX_LIMIT: limit_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_xfer) begin
        run_value_r <= run_value_nxt;
        run_count_r <= run_count_nxt;
        bytes_out_r <= bytes_out_nxt;
        failed_r    <= failed_nxt;
      end
    end
  end

  prle_out_buf u_out_buf (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (in_xfer && grp.cnt != 3'd0),
    .grp            (grp),
    .ready          (buf_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_status     (out_status),
    .out_total_size (out_total_size)
  );

  a_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    run_count_r <= MaxRun8)
    else $error("run longer than maximum");

  a_failed_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |-> (run_count_r == 8'd0 && bytes_out_r == 14'd0))
    else $error("dropped page still holds state");

  // the limit may be lowered inside a page, so only growth is checked
  a_bytes_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_xfer) && !$past(cfg_wr_en) && (bytes_out_r > $past(bytes_out_r))
      |-> ({1'b0, bytes_out_r} <= lim))
    else $error("output count over limit");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for page_run_length_encoder_core: drives pages of bytes
// with random gaps, predicts the count/value pairs, copy bytes, and no-space
// results in step with each input transfer, and checks every output transfer.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_RUN       = 255;
  localparam int LIMIT_MAX     = 8192;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 160;
  localparam int MAX_REPORTS   = 10;

  localparam logic [1:0] MODE_RLE_1 = 2'd1;
  localparam logic [1:0] MODE_RLE_2 = 2'd2;
  localparam logic [1:0] MODE_RLE_3 = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_page_end;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_status;
  logic [13:0] out_total_size;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [13:0] cfg_data;

  page_run_length_encoder_core #(
    .MAX_RUN  (MAX_RUN),
    .LIMIT_MAX(LIMIT_MAX)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_page_end   (in_page_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .out_status    (out_status),
    .out_total_size(out_total_size),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // encoder state as predicted by the bench
  logic [1:0]        enc_mode;
  logic [13:0]       enc_limit;
  logic [7:0]        run_val;
  logic [7:0]        run_len;
  logic [13:0]       page_bytes;
  bit                page_dropped;
  prle_pkg::entry_t  encoded_q[$];

  bit gaps_on;
  bit stall_gaps_on;
  int items_sent;
  int results_seen;
  int pages_closed;
  int no_space_seen;
  int cfg_writes;
  int mismatches;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic int eff_limit();
    return (int'(enc_limit) > LIMIT_MAX) ? LIMIT_MAX : int'(enc_limit);
  endfunction

  function automatic void push_out(logic [7:0] d, logic l, logic s, logic [13:0] sz);
    prle_pkg::entry_t x;
    x.data   = d;
    x.last   = l;
    x.status = s;
    x.size   = sz;
    encoded_q.push_back(x);
  endfunction

  function automatic void clear_page();
    run_val      = 8'd0;
    run_len      = 8'd0;
    page_bytes   = 14'd0;
    page_dropped = 1'b0;
  endfunction

  function automatic void drop_page(logic at_end);
    push_out(8'd0, 1'b1, prle_pkg::STATUS_NO_SPACE, 14'd0);
    clear_page();
    if (!at_end) page_dropped = 1'b1;
  endfunction

  // a pair needs room for both bytes
  function automatic bit flush_pair(logic at_end);
    if (int'(page_bytes) + 2 > eff_limit()) return 1'b0;
    page_bytes = page_bytes + 14'd2;
    push_out(run_len, 1'b0, prle_pkg::STATUS_OK, 14'd0);
    push_out(run_val, at_end, prle_pkg::STATUS_OK, at_end ? page_bytes : 14'd0);
    run_len = 8'd0;
    return 1'b1;
  endfunction

  function automatic void encode_byte(logic [7:0] b, logic at_end);
    if (page_dropped) begin
      if (at_end) clear_page();
      return;
    end
    if (enc_mode == prle_pkg::MODE_COPY) begin
      if (run_len != 0 && !flush_pair(1'b0)) begin
        drop_page(at_end);
        return;
      end
      if (int'(page_bytes) + 1 > eff_limit()) begin
        drop_page(at_end);
        return;
      end
      page_bytes = page_bytes + 14'd1;
      push_out(b, at_end, prle_pkg::STATUS_OK, at_end ? page_bytes : 14'd0);
      if (at_end) clear_page();
      return;
    end
    if (run_len != 0 && (b != run_val || int'(run_len) >= MAX_RUN)) begin
      if (!flush_pair(1'b0)) begin
        drop_page(at_end);
        return;
      end
    end
    if (run_len == 0) begin
      run_val = b;
      run_len = 8'd1;
    end else begin
      run_len = run_len + 8'd1;
    end
    if (at_end) begin
      if (!flush_pair(1'b1)) begin
        drop_page(1'b1);
        return;
      end
      clear_page();
    end
  endfunction

  // ------------------------------------------- monitor, checker and watchdog
  always @(posedge clk) begin
    prle_pkg::entry_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_last) pages_closed++;
        if (out_status == prle_pkg::STATUS_NO_SPACE) no_space_seen++;
        if (encoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result byte %02h last %0b status %0b size %0d",
                     out_byte, out_last, out_status, out_total_size);
        end else begin
          want = encoded_q.pop_front();
          if (out_byte !== want.data || out_last !== want.last ||
              out_status !== want.status || out_total_size !== want.size) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"result %0d: expected byte %02h last %0b status %0b size %0d,",
                        " got %02h %0b %0b %0d"},
                       results_seen, want.data, want.last, want.status, want.size,
                       out_byte, out_last, out_status, out_total_size);
          end
        end
      end
      // output of this edge cannot belong to the byte taken at this edge
      if (in_valid && !in_stall) encode_byte(in_data_byte, in_page_end);

      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d results pending",
                 idle_cycles, encoded_q.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ----------------------------------------------------------------- receiver
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      n = stall_gaps_on ? $urandom_range(0, 14) : 0;
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  // ------------------------------------------------------------------ sender
  task automatic send_byte(input logic [7:0] b, input logic at_end);
    int gap;
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_page_end  <= at_end;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (encoded_q.size() != 0) @(posedge clk);
  endtask

  // writes only once every result is out and the pipe has settled
  task automatic cfg_write(input logic idx, input logic [13:0] val);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == prle_pkg::CFG_IDX_MODE) enc_mode = val[1:0];
    else enc_limit = val;
    cfg_writes++;
  endtask

  task automatic send_page(input int nbytes, input int max_len);
    int left;
    int len;
    logic [7:0] v;
    left = nbytes;
    while (left > 0) begin
      len = $urandom_range(1, max_len);
      if (len > left) len = left;
      v = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 3));
      repeat (len) begin
        left--;
        send_byte(v, left == 0);
      end
    end
  endtask

  // broken pages: page_end scattered at random
  task automatic send_noise(input int nbytes);
    repeat (nbytes) send_byte(8'($urandom), $urandom_range(0, 5) == 0);
  endtask

  // ------------------------------------------------------------------- tests
  task automatic test_encode_basics();
    cfg_write(prle_pkg::CFG_IDX_MODE, 14'(MODE_RLE_1));
    cfg_write(prle_pkg::CFG_IDX_LIMIT, 14'(LIMIT_MAX));
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
  endtask

  task automatic test_copy_mode();
    cfg_write(prle_pkg::CFG_IDX_MODE, 14'(prle_pkg::MODE_COPY));
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h0F, 1'b1);
  endtask

  task automatic test_mode_switch_in_page();
    // open run is flushed as a pair by the first copy byte
    cfg_write(prle_pkg::CFG_IDX_MODE, 14'(MODE_RLE_2));
    send_byte(8'h33, 1'b0);
    send_byte(8'h33, 1'b0);
    cfg_write(prle_pkg::CFG_IDX_MODE, 14'(prle_pkg::MODE_COPY));
    send_byte(8'hC3, 1'b0);
    cfg_write(prle_pkg::CFG_IDX_MODE, 14'(MODE_RLE_3));
    send_byte(8'hC3, 1'b1);
  endtask

  task automatic test_output_limit();
    cfg_write(prle_pkg::CFG_IDX_MODE, 14'(prle_pkg::MODE_COPY));
    cfg_write(prle_pkg::CFG_IDX_LIMIT, 14'd0);
    send_byte(8'h7E, 1'b1);
    cfg_write(prle_pkg::CFG_IDX_MODE, 14'(MODE_RLE_1));
    cfg_write(prle_pkg::CFG_IDX_LIMIT, 14'd1);
    send_byte(8'h44, 1'b1);
    // second pair does not fit, rest of the page is dropped
    cfg_write(prle_pkg::CFG_IDX_LIMIT, 14'd3);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'h05, 1'b1);
    send_byte(8'h06, 1'b1);
    cfg_write(prle_pkg::CFG_IDX_LIMIT, 14'd2);
    send_byte(8'h80, 1'b1);
    cfg_write(prle_pkg::CFG_IDX_LIMIT, 14'h3FFF);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_run_cap();
    logic [7:0] v;
    cfg_write(prle_pkg::CFG_IDX_MODE, 14'(MODE_RLE_1));
    cfg_write(prle_pkg::CFG_IDX_LIMIT, 14'(LIMIT_MAX));
    gaps_on       = 1'b0;
    stall_gaps_on = 1'b0;
    v = 8'($urandom);
    repeat (MAX_RUN + 1) send_byte(v, 1'b0);
    send_byte(v, 1'b1);
    gaps_on       = 1'b1;
    stall_gaps_on = 1'b1;
  endtask

  task automatic test_random_pages();
    int start;
    int phase;
    logic [13:0] lim;
    start = items_sent;
    phase = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      cfg_write(prle_pkg::CFG_IDX_MODE,
                (phase == 0) ? 14'(prle_pkg::MODE_COPY) : 14'($urandom_range(0, 3)));
      case ($urandom_range(0, 5))
        0, 1, 2: lim = 14'($urandom_range(0, 48));
        3:       lim = 14'($urandom_range(49, LIMIT_MAX));
        4:       lim = 14'(LIMIT_MAX);
        default: lim = 14'($urandom_range(LIMIT_MAX + 1, 16383));
      endcase
      cfg_write(prle_pkg::CFG_IDX_LIMIT, lim);
      gaps_on       = (phase % 3) != 2;
      stall_gaps_on = (phase % 4) != 3;
      repeat ($urandom_range(2, 5)) begin
        if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 8));
        else send_page($urandom_range(1, 24), $urandom_range(0, 3) == 0 ? 12 : 4);
        // in phase 1 the sender holds off until the block has caught up
        if (phase == 1) wait_drained();
      end
      phase++;
    end
    gaps_on       = 1'b1;
    stall_gaps_on = 1'b1;
  endtask

  initial begin
    in_valid      = 1'b0;
    in_data_byte  = 8'd0;
    in_page_end   = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = prle_pkg::CFG_IDX_MODE;
    cfg_data      = 14'd0;
    gaps_on       = 1'b1;
    stall_gaps_on = 1'b1;
    items_sent    = 0;
    results_seen  = 0;
    pages_closed  = 0;
    no_space_seen = 0;
    cfg_writes    = 0;
    mismatches    = 0;
    idle_cycles   = 0;
    enc_mode      = MODE_RLE_1;
    enc_limit     = 14'(LIMIT_MAX);
    clear_page();
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_encode_basics();
    test_copy_mode();
    test_mode_switch_in_page();
    test_output_limit();
    test_run_cap();
    test_random_pages();

    wait_drained();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (encoded_q.size() != 0) mismatches++;

    $display("sent %0d bytes, checked %0d results over %0d pages, %0d no-space events",
             items_sent, results_seen, pages_closed, no_space_seen);
    $display("%0d register writes across copy and encode modes, limits 0 to saturated",
             cfg_writes);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== page_run_length_encoder_core.f =====
sv/prle_pkg.sv
sv/prle_out_buf.sv
sv/page_run_length_encoder_core.sv
tb/sv/testbench.sv
